FILE: rtl/core/wss_pkg.sv
// Package for the waypoint steering step: payload and cell types, fixed constants
// and the arctangent table shared by the CORDIC cells.
// No dependencies.
package wss_pkg;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 24;
  localparam int ATAN_LEN   = 24;
  localparam logic [29:0] GAIN_Q30 = 30'd652032875;

  localparam logic [2:0] CFG_ARRIVAL_RADIUS  = 3'd0;
  localparam logic [2:0] CFG_EASE_RANGE      = 3'd1;
  localparam logic [2:0] CFG_MAX_STEER_ANGLE = 3'd2;
  localparam logic [2:0] CFG_TURN_RATE       = 3'd3;
  localparam logic [2:0] CFG_MAX_SPEED       = 3'd4;

  // Everything an item carries along the pipe besides the working data of a chain.
  typedef struct packed {
    logic               tgt;
    logic               arr;
    logic               use_div;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic [15:0]        head;
    logic [15:0]        el;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [1:0]         sh;
    logic [33:0]        span;
    logic [31:0]        bear;
    logic [15:0]        newh;
    logic [23:0]        travel;
  } pl_t;

  typedef struct packed {
    logic [63:0] v;
    logic [34:0] r;
    logic [31:0] q;
  } sqrt_t;

  typedef struct packed {
    logic signed [35:0] x;
    logic signed [35:0] y;
    logic [31:0]        z;
  } vec_t;

  typedef struct packed {
    logic [23:0] rem;
    logic [23:0] n;
    logic [23:0] q;
  } div_t;

  typedef struct packed {
    logic signed [27:0] x;
    logic signed [27:0] y;
    logic signed [33:0] z;
  } rot_t;

  // atan(2^-i) in units of 2^-32 turn.
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] a;
    case (idx)
      5'd0:    a = 32'd536870912;
      5'd1:    a = 32'd316933406;
      5'd2:    a = 32'd167458907;
      5'd3:    a = 32'd85004756;
      5'd4:    a = 32'd42667331;
      5'd5:    a = 32'd21354465;
      5'd6:    a = 32'd10679838;
      5'd7:    a = 32'd5340245;
      5'd8:    a = 32'd2670163;
      5'd9:    a = 32'd1335087;
      5'd10:   a = 32'd667544;
      5'd11:   a = 32'd333772;
      5'd12:   a = 32'd166886;
      5'd13:   a = 32'd83443;
      5'd14:   a = 32'd41722;
      5'd15:   a = 32'd20861;
      5'd16:   a = 32'd10430;
      5'd17:   a = 32'd5215;
      5'd18:   a = 32'd2608;
      5'd19:   a = 32'd1304;
      5'd20:   a = 32'd652;
      5'd21:   a = 32'd326;
      5'd22:   a = 32'd163;
      5'd23:   a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

FILE: rtl/core/wss_sqrt_cell.sv
// One digit cell of the integer square root chain: two radicand bits per cell.
// Depends on wss_pkg.
module wss_sqrt_cell import wss_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  i_vld,
  input  pl_t   i_pl,
  input  sqrt_t i_d,
  output logic  o_vld,
  output pl_t   o_pl,
  output sqrt_t o_d
);

  logic  vld_r;
  pl_t   pl_r;
  sqrt_t d_r, d_nxt;
  logic [34:0] r_sh, trial;

  always_comb begin
    r_sh  = {i_d.r[32:0], i_d.v[63:62]};
    trial = {1'b0, i_d.q, 2'b01};
    d_nxt.v = {i_d.v[61:0], 2'b00};
    if (r_sh >= trial) begin
      d_nxt.r = r_sh - trial;
      d_nxt.q = {i_d.q[30:0], 1'b1};
    end else begin
      d_nxt.r = r_sh;
      d_nxt.q = {i_d.q[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= i_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl_r <= i_pl;
      d_r  <= d_nxt;
    end
  end

  assign o_vld = vld_r;
  assign o_pl  = pl_r;
  assign o_d   = d_r;

endmodule

FILE: rtl/core/wss_vec_cell.sv
// One micro-rotation of the vectoring CORDIC that finds the bearing to the target.
// Depends on wss_pkg.
module wss_vec_cell import wss_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic i_vld,
  input  pl_t  i_pl,
  input  vec_t i_d,
  output logic o_vld,
  output pl_t  o_pl,
  output vec_t o_d
);

  logic  vld_r;
  pl_t   pl_r;
  vec_t  d_r, d_nxt;
  logic signed [35:0] x, y, xs, ys;
  logic [31:0] at;

  always_comb begin
    x  = i_d.x;
    y  = i_d.y;
    xs = x >>> IDX;
    ys = y >>> IDX;
    at = atan_turn(5'(IDX));
    if (y > 36'sd0) begin
      d_nxt.x = x + ys;
      d_nxt.y = y - xs;
      d_nxt.z = i_d.z + at;
    end else begin
      d_nxt.x = x - ys;
      d_nxt.y = y + xs;
      d_nxt.z = i_d.z - at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= i_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl_r <= i_pl;
      d_r  <= d_nxt;
    end
  end

  assign o_vld = vld_r;
  assign o_pl  = pl_r;
  assign o_d   = d_r;

endmodule

FILE: rtl/core/wss_div_cell.sv
// One restoring step of the speed divider: one quotient bit per cell.
// Depends on wss_pkg.
module wss_div_cell import wss_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic [23:0] divisor,
  input  logic        i_vld,
  input  pl_t         i_pl,
  input  div_t        i_d,
  output logic        o_vld,
  output pl_t         o_pl,
  output div_t        o_d
);

  logic  vld_r;
  pl_t   pl_r;
  div_t  d_r, d_nxt;
  logic [24:0] t, diff;

  always_comb begin
    t    = {i_d.rem, i_d.n[23]};
    diff = t - {1'b0, divisor};
    d_nxt.n = {i_d.n[22:0], 1'b0};
    if (t >= {1'b0, divisor}) begin
      d_nxt.rem = diff[23:0];
      d_nxt.q   = {i_d.q[22:0], 1'b1};
    end else begin
      d_nxt.rem = t[23:0];
      d_nxt.q   = {i_d.q[22:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= i_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl_r <= i_pl;
      d_r  <= d_nxt;
    end
  end

  assign o_vld = vld_r;
  assign o_pl  = pl_r;
  assign o_d   = d_r;

endmodule

FILE: rtl/core/wss_rot_cell.sv
// One micro-rotation of the rotation CORDIC that turns the travel along the heading.
// Depends on wss_pkg.
module wss_rot_cell import wss_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic i_vld,
  input  pl_t  i_pl,
  input  rot_t i_d,
  output logic o_vld,
  output pl_t  o_pl,
  output rot_t o_d
);

  logic  vld_r;
  pl_t   pl_r;
  rot_t  d_r, d_nxt;
  logic signed [27:0] x, y, xs, ys;
  logic signed [33:0] z, at;

  always_comb begin
    x  = i_d.x;
    y  = i_d.y;
    z  = i_d.z;
    xs = x >>> IDX;
    ys = y >>> IDX;
    at = $signed({2'b00, atan_turn(5'(IDX))});
    if (z >= 34'sd0) begin
      d_nxt.x = x - ys;
      d_nxt.y = y + xs;
      d_nxt.z = z - at;
    end else begin
      d_nxt.x = x + ys;
      d_nxt.y = y - xs;
      d_nxt.z = z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= i_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl_r <= i_pl;
      d_r  <= d_nxt;
    end
  end

  assign o_vld = vld_r;
  assign o_pl  = pl_r;
  assign o_d   = d_r;

endmodule

FILE: rtl/core/waypoint_steer_step.sv
// Top level of the waypoint steering step: front stages, the cell chains and the
// output register. Depends on wss_pkg and the four cell modules.
//
//   channel | ports                               | direction
//   input   | in_valid, in_stall, in_* fields     | upstream to block
//   result  | out_valid, out_stall, out_* fields  | block to downstream
//   config  | cfg_we, cfg_index, cfg_wdata        | host to block
//
// One transaction enters per cycle while the pipe is not stalled.
// The latency is set by the 32-cell square root chain, the 24-cell divider chain and
// the two CORDIC chains. Reset is synchronous and empties the pipe and loads the
// register defaults. When the output register holds a result under stall the whole
// chain holds and in_stall is raised.
module waypoint_steer_step import wss_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_has_target,
  input  logic signed [31:0] in_target_x,
  input  logic signed [31:0] in_target_y,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic [15:0]        in_heading,
  input  logic [15:0]        in_elapsed,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_new_x,
  output logic signed [31:0] out_new_y,
  output logic [15:0]        out_new_heading,
  output logic               out_arrived,
  output logic               out_moved,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_wdata
);

  localparam int NC = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

  logic [23:0] arrival_radius_r, ease_range_r, max_speed_r;
  logic [15:0] max_steer_angle_r;
  logic [21:0] turn_rate_r;

  logic en;

  // Register file.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arrival_radius_r  <= 24'd25600;
      ease_range_r      <= 24'd128000;
      max_steer_angle_r <= 16'd8192;
      turn_rate_r       <= 22'd16384;
      max_speed_r       <= 24'd256000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ARRIVAL_RADIUS:  arrival_radius_r  <= cfg_wdata;
        CFG_EASE_RANGE:      ease_range_r      <= cfg_wdata;
        CFG_MAX_STEER_ANGLE: max_steer_angle_r <= cfg_wdata[15:0];
        CFG_TURN_RATE:       turn_rate_r       <= cfg_wdata[21:0];
        CFG_MAX_SPEED:       max_speed_r       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------- front: differences, scaling, squares ----------------
  logic        v1_r, v2_r, v3_r;
  pl_t         p1_r, p2_r, p3_r, p1_nxt;
  logic [30:0] a1_r, b1_r, a1_nxt, b1_nxt;
  logic [61:0] sqa_r, sqb_r;
  logic [62:0] sum_r;
  logic signed [32:0] dx, dy;
  logic [32:0] ax, ay;

  always_comb begin
    dx = {in_target_x[31], in_target_x} - {in_pos_x[31], in_pos_x};
    dy = {in_target_y[31], in_target_y} - {in_pos_y[31], in_pos_y};
    ax = dx[32] ? (33'd0 - dx) : dx;
    ay = dy[32] ? (33'd0 - dy) : dy;
    p1_nxt      = '0;
    p1_nxt.tgt  = in_has_target;
    p1_nxt.px   = in_pos_x;
    p1_nxt.py   = in_pos_y;
    p1_nxt.head = in_heading;
    p1_nxt.el   = in_elapsed;
    p1_nxt.dx   = dx;
    p1_nxt.dy   = dy;
    // Both magnitudes are brought below 2^31 by a common shift.
    if (ax[32] || ay[32]) begin
      p1_nxt.sh = 2'd2;
    end else if (ax[31] || ay[31]) begin
      p1_nxt.sh = 2'd1;
    end else begin
      p1_nxt.sh = 2'd0;
    end
    a1_nxt = 31'(ax >> p1_nxt.sh);
    b1_nxt = 31'(ay >> p1_nxt.sh);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r  <= p1_nxt;
      a1_r  <= a1_nxt;
      b1_r  <= b1_nxt;
      p2_r  <= p1_r;
      sqa_r <= 62'(a1_r) * 62'(a1_r);
      sqb_r <= 62'(b1_r) * 62'(b1_r);
      p3_r  <= p2_r;
      sum_r <= 63'(sqa_r) + 63'(sqb_r);
    end
  end

  // ---------------- square root chain ----------------
  logic  sq_vld [SQRT_STEPS+1];
  pl_t   sq_pl  [SQRT_STEPS+1];
  sqrt_t sq_d   [SQRT_STEPS+1];

  assign sq_vld[0]  = v3_r;
  assign sq_pl[0]   = p3_r;
  assign sq_d[0].v  = {1'b0, sum_r};
  assign sq_d[0].r  = '0;
  assign sq_d[0].q  = '0;

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    wss_sqrt_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .i_vld(sq_vld[g]), .i_pl(sq_pl[g]), .i_d(sq_d[g]),
      .o_vld(sq_vld[g+1]), .o_pl(sq_pl[g+1]), .o_d(sq_d[g+1])
    );
  end

  // ---------------- bearing: vectoring CORDIC chain ----------------
  logic  v0_r;
  pl_t   pv0_r, pv0_nxt;
  vec_t  dv0_r, dv0_nxt;
  logic signed [35:0] x0, y0;

  always_comb begin
    pv0_nxt      = sq_pl[SQRT_STEPS];
    pv0_nxt.span = 34'(sq_d[SQRT_STEPS].q) << sq_pl[SQRT_STEPS].sh;
    x0 = 36'(sq_pl[SQRT_STEPS].dx);
    y0 = 36'(sq_pl[SQRT_STEPS].dy);
    // Left half plane: rotate by a half turn first.
    if (x0 < 36'sd0) begin
      dv0_nxt.x = -x0;
      dv0_nxt.y = -y0;
      dv0_nxt.z = 32'h8000_0000;
    end else begin
      dv0_nxt.x = x0;
      dv0_nxt.y = y0;
      dv0_nxt.z = 32'h0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= sq_vld[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pv0_r <= pv0_nxt;
      dv0_r <= dv0_nxt;
    end
  end

  logic vc_vld [NC+1];
  pl_t  vc_pl  [NC+1];
  vec_t vc_d   [NC+1];

  assign vc_vld[0] = v0_r;
  assign vc_pl[0]  = pv0_r;
  assign vc_d[0]   = dv0_r;

  for (genvar g = 0; g < NC; g++) begin : g_vec
    wss_vec_cell #(.IDX(g)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .i_vld(vc_vld[g]), .i_pl(vc_pl[g]), .i_d(vc_d[g]),
      .o_vld(vc_vld[g+1]), .o_pl(vc_pl[g+1]), .o_d(vc_d[g+1])
    );
  end

  // ---------------- steering error, turn budget, speed numerator ----------------
  logic        e1_vld_r, e2_vld_r;
  pl_t         pe1_r, pe1_nxt, pe2_r, pe2_nxt;
  logic [15:0] err1_r, err1_nxt, bear16;
  logic [21:0] cap1_r, cap1_nxt;
  logic [47:0] num1_r, num1_nxt;
  logic [33:0] diff;
  logic [37:0] cap_prod;
  div_t        dd0_r, dd0_nxt;
  logic signed [16:0] e17, lim17;
  logic signed [22:0] e23, cap23;

  always_comb begin
    pe1_nxt = vc_pl[NC];
    // A target exactly on the vehicle takes bearing zero.
    if (vc_pl[NC].dx == 33'sd0 && vc_pl[NC].dy == 33'sd0) begin
      pe1_nxt.bear = 32'h0;
    end else begin
      pe1_nxt.bear = vc_d[NC].z;
    end
    bear16   = 16'((pe1_nxt.bear + 32'h0000_8000) >> 16);
    err1_nxt = bear16 - vc_pl[NC].head;
    pe1_nxt.arr = vc_pl[NC].tgt && (vc_pl[NC].span < 34'(arrival_radius_r));
    diff = vc_pl[NC].span - 34'(arrival_radius_r);
    pe1_nxt.use_div = (ease_range_r != 24'd0) && (diff < 34'(ease_range_r));
    num1_nxt = 48'(max_speed_r) * 48'(diff[23:0]);
    cap_prod = 38'(turn_rate_r) * 38'(vc_pl[NC].el);
    cap1_nxt = cap_prod[37:16];
  end

  always_comb begin
    e17   = {err1_r[15], err1_r};
    lim17 = $signed({1'b0, max_steer_angle_r});
    if (e17 > lim17) begin
      e17 = lim17;
    end
    if (e17 < -lim17) begin
      e17 = -lim17;
    end
    e23   = 23'(e17);
    cap23 = $signed({1'b0, cap1_r});
    if (e23 > cap23) begin
      e23 = cap23;
    end
    if (e23 < -cap23) begin
      e23 = -cap23;
    end
    pe2_nxt      = pe1_r;
    pe2_nxt.newh = pe1_r.head + e23[15:0];
    dd0_nxt.rem  = num1_r[47:24];
    dd0_nxt.n    = num1_r[23:0];
    dd0_nxt.q    = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_vld_r <= 1'b0;
      e2_vld_r <= 1'b0;
    end else if (en) begin
      e1_vld_r <= vc_vld[NC];
      e2_vld_r <= e1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pe1_r  <= pe1_nxt;
      err1_r <= err1_nxt;
      cap1_r <= cap1_nxt;
      num1_r <= num1_nxt;
      pe2_r  <= pe2_nxt;
      dd0_r  <= dd0_nxt;
    end
  end

  // ---------------- speed divider chain ----------------
  logic dc_vld [DIV_STEPS+1];
  pl_t  dc_pl  [DIV_STEPS+1];
  div_t dc_d   [DIV_STEPS+1];

  assign dc_vld[0] = e2_vld_r;
  assign dc_pl[0]  = pe2_r;
  assign dc_d[0]   = dd0_r;

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    wss_div_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .divisor(ease_range_r),
      .i_vld(dc_vld[g]), .i_pl(dc_pl[g]), .i_d(dc_d[g]),
      .o_vld(dc_vld[g+1]), .o_pl(dc_pl[g+1]), .o_d(dc_d[g+1])
    );
  end

  // ---------------- travel and gain compensation ----------------
  logic        t1_vld_r, t2_vld_r, r0_vld_r;
  pl_t         pt1_r, pt2_r, pt2_nxt, pr0_r;
  logic [23:0] trav1_r, speed;
  logic [39:0] tprod;
  logic [53:0] gprod;
  rot_t        dr0_r, dr0_nxt;
  logic        flip;
  logic [31:0] ang;

  always_comb begin
    speed = dc_pl[DIV_STEPS].use_div ? dc_d[DIV_STEPS].q : max_speed_r;
    tprod = 40'(speed) * 40'(dc_pl[DIV_STEPS].el);
    gprod = 54'(trav1_r) * 54'(GAIN_Q30);
    pt2_nxt        = pt1_r;
    pt2_nxt.travel = gprod[53:30];
    // Headings in the back half start from the negated vector.
    flip = (pt2_r.newh >= 16'h4000) && (pt2_r.newh < 16'hC000);
    ang  = {pt2_r.newh, 16'h0000} - (flip ? 32'h8000_0000 : 32'h0);
    dr0_nxt.x = flip ? -$signed({4'b0000, pt2_r.travel}) : $signed({4'b0000, pt2_r.travel});
    dr0_nxt.y = '0;
    dr0_nxt.z = 34'($signed(ang));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_vld_r <= 1'b0;
      t2_vld_r <= 1'b0;
      r0_vld_r <= 1'b0;
    end else if (en) begin
      t1_vld_r <= dc_vld[DIV_STEPS];
      t2_vld_r <= t1_vld_r;
      r0_vld_r <= t2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pt1_r   <= dc_pl[DIV_STEPS];
      trav1_r <= tprod[39:16];
      pt2_r   <= pt2_nxt;
      pr0_r   <= pt2_r;
      dr0_r   <= dr0_nxt;
    end
  end

  // ---------------- position step: rotation CORDIC chain ----------------
  logic rc_vld [NC+1];
  pl_t  rc_pl  [NC+1];
  rot_t rc_d   [NC+1];

  assign rc_vld[0] = r0_vld_r;
  assign rc_pl[0]  = pr0_r;
  assign rc_d[0]   = dr0_r;

  for (genvar g = 0; g < NC; g++) begin : g_rot
    wss_rot_cell #(.IDX(g)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .i_vld(rc_vld[g]), .i_pl(rc_pl[g]), .i_d(rc_d[g]),
      .o_vld(rc_vld[g+1]), .o_pl(rc_pl[g+1]), .o_d(rc_d[g+1])
    );
  end

  // ---------------- output register ----------------
  logic               out_valid_r;
  logic signed [31:0] out_x_r, out_y_r, out_x_nxt, out_y_nxt, sat_x, sat_y;
  logic [15:0]        out_h_r, out_h_nxt;
  logic               out_arr_r, out_mov_r, out_arr_nxt, out_mov_nxt;
  logic signed [32:0] sx, sy;
  pl_t                pf;

  always_comb begin
    pf = rc_pl[NC];
    sx = 33'(pf.px) + 33'(rc_d[NC].x);
    sy = 33'(pf.py) + 33'(rc_d[NC].y);
    if (sx[32] != sx[31]) begin
      sat_x = sx[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sat_x = sx[31:0];
    end
    if (sy[32] != sy[31]) begin
      sat_y = sy[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sat_y = sy[31:0];
    end
    if (pf.tgt && !pf.arr) begin
      out_x_nxt   = sat_x;
      out_y_nxt   = sat_y;
      out_h_nxt   = pf.newh;
      out_arr_nxt = 1'b0;
      out_mov_nxt = 1'b1;
    end else begin
      out_x_nxt   = pf.px;
      out_y_nxt   = pf.py;
      out_h_nxt   = pf.head;
      out_arr_nxt = pf.arr;
      out_mov_nxt = 1'b0;
    end
  end

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= rc_vld[NC];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x_r   <= out_x_nxt;
      out_y_r   <= out_y_nxt;
      out_h_r   <= out_h_nxt;
      out_arr_r <= out_arr_nxt;
      out_mov_r <= out_mov_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_new_x       = out_x_r;
  assign out_new_y       = out_y_r;
  assign out_new_heading = out_h_r;
  assign out_arrived     = out_arr_r;
  assign out_moved       = out_mov_r;

  // A tick either arrives or moves, never both.
  a_arr_mov_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_arrived && out_moved))
    else $error("arrived and moved both set");

  // An empty output register never holds back the input.
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output register");

  // A result held under stall keeps the whole pipe frozen, so the next result
  // cannot appear before the held one is taken.
  a_hold_output: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_new_x) && $stable(out_moved))
    else $error("held result changed under stall");

endmodule
